/* design/sli_pkg.sv */
// Package for the sorted list insert/delete block.
// Holds the value width, the sequencer state type and the operation codes; no dependencies.
`default_nettype none

package sli_pkg;

    // Width of one stored value.
    localparam int unsigned DATA_W = 32;

    // Operation codes carried by the mode field of a request.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_STEP
    } t_state;

endpackage : sli_pkg

`default_nettype wire

/* design/sli_in_if.sv */
// Input channel of the sorted list block: valid/ready plus one operation request.
// Depends on sli_pkg for the value width.
`default_nettype none

interface sli_in_if
    import sli_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface : sli_in_if

`default_nettype wire

/* design/sli_out_if.sv */
// Output channel of the sorted list block: valid/ready plus one list entry.
// Depends on sli_pkg for the value width.
`default_nettype none

interface sli_out_if
    import sli_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item_value;
    logic                     list_empty;
    logic                     last;
    logic                     insert_dropped;

    modport source (output valid, output item_value, output list_empty,
                    output last, output insert_dropped, input ready);
    modport sink   (input valid, input item_value, input list_empty,
                    input last, input insert_dropped, output ready);
endinterface : sli_out_if

`default_nettype wire

/* design/sorted_list_insert_delete_top.sv */
// Sorted multiset store with insert/delete requests and a full list dump per request.
// Depends on sli_pkg, sli_in_if and sli_out_if.
//
//  channel | direction | payload                                          | handshake
//  i_in    | in        | mode, value                                      | valid/ready
//  o_out   | out       | item_value, list_empty, last, insert_dropped     | valid/ready
//
// A request runs one compare step per old entry in the shared compare unit,
// one step for an insert that is not dropped and one closing step; every
// matching copy is dropped on a delete.
// The list lives in two banks; each request streams the old bank into the other.
// Reset clears the entry count and the sequencer; the banks are not cleared.
// A stalled output holds the sequencer; the next request is taken while the
// final result of the previous one still waits in the output register.
`default_nettype none

module sorted_list_insert_delete_top
    import sli_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sli_in_if.sink     i_in,
    sli_out_if.source  o_out
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Two storage banks, ping-ponged per request.
    logic signed [DATA_W-1:0] r_mem0 [CAPACITY];
    logic signed [DATA_W-1:0] r_mem1 [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata0, r_rdata1;

    t_state r_state, n_state;
    logic   r_bank, n_bank;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    logic   r_mode, n_mode;
    logic   r_drop, n_drop;
    logic   r_ins_done, n_ins_done;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic   r_pend_valid, n_pend_valid;
    logic signed [DATA_W-1:0] r_pend_value, n_pend_value;

    logic   r_o_valid, n_o_valid;
    logic signed [DATA_W-1:0] r_o_value, n_o_value;
    logic   r_o_empty, n_o_empty;
    logic   r_o_last, n_o_last;
    logic   r_o_drop, n_o_drop;

    logic   wr_en;
    logic signed [DATA_W-1:0] wr_data;
    logic   in_acc;
    logic   step_fin;
    logic   out_free;
    logic   have_old;
    logic   ins_pend;
    logic   cmp_le, cmp_eq;
    logic signed [DATA_W-1:0] old_value;

    assign in_acc    = (r_state == S_IDLE) && i_in.valid;
    assign out_free  = !r_o_valid || o_out.ready;
    assign old_value = r_bank ? r_rdata1 : r_rdata0;
    assign have_old  = (r_rd < r_count);
    assign ins_pend  = (r_mode == MODE_INSERT) && !r_drop && !r_ins_done;

    // Shared compare unit: request value against the current old entry.
    assign cmp_le = (r_value <= old_value);
    assign cmp_eq = (r_value == old_value);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (step_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control: merge the request into the streamed list.
    always_comb begin
        n_bank       = r_bank;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_mode       = r_mode;
        n_drop       = r_drop;
        n_ins_done   = r_ins_done;
        n_value      = r_value;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_o_valid    = r_o_valid && !o_out.ready;
        n_o_value    = r_o_value;
        n_o_empty    = r_o_empty;
        n_o_last     = r_o_last;
        n_o_drop     = r_o_drop;
        wr_en        = 1'b0;
        wr_data      = r_value;
        step_fin     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode       = i_in.mode;
                    n_value      = i_in.value;
                    n_drop       = (i_in.mode == MODE_INSERT) &&
                                   (r_count >= CW'(CAPACITY));
                    n_rd         = '0;
                    n_wr         = '0;
                    n_ins_done   = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end
            S_STEP: begin
                if (out_free) begin
                    if (have_old && ins_pend && cmp_le) begin
                        // New value goes in front of the first entry not below it.
                        wr_en      = 1'b1;
                        wr_data    = r_value;
                        n_ins_done = 1'b1;
                    end else if (have_old && (r_mode == MODE_DELETE) && cmp_eq) begin
                        // Matching copy is dropped from the new list.
                        n_rd = r_rd + CW'(1);
                    end else if (have_old) begin
                        wr_en   = 1'b1;
                        wr_data = old_value;
                        n_rd    = r_rd + CW'(1);
                    end else if (ins_pend) begin
                        // New value is the largest: append it.
                        wr_en      = 1'b1;
                        wr_data    = r_value;
                        n_ins_done = 1'b1;
                    end else begin
                        // Close the request with the held entry or an empty marker.
                        step_fin  = 1'b1;
                        n_o_valid = 1'b1;
                        n_o_value = r_pend_valid ? r_pend_value : '0;
                        n_o_empty = !r_pend_valid;
                        n_o_last  = 1'b1;
                        n_o_drop  = r_drop;
                        n_count   = r_wr;
                        n_bank    = !r_bank;
                    end

                    // Each new entry releases the one held before it.
                    if (wr_en) begin
                        n_wr         = r_wr + CW'(1);
                        n_pend_valid = 1'b1;
                        n_pend_value = wr_data;
                        if (r_pend_valid) begin
                            n_o_valid = 1'b1;
                            n_o_value = r_pend_value;
                            n_o_empty = 1'b0;
                            n_o_last  = 1'b0;
                            n_o_drop  = r_drop;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Bank writes go to the inactive bank.
    always_ff @(posedge i_clk) begin
        if (wr_en && r_bank) begin
            r_mem0[r_wr[AW-1:0]] <= wr_data;
        end
        if (wr_en && !r_bank) begin
            r_mem1[r_wr[AW-1:0]] <= wr_data;
        end
    end

    // Registered reads at the next read index.
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem0[n_rd[AW-1:0]];
        r_rdata1 <= r_mem1[n_rd[AW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bank    <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bank    <= n_bank;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_rd         <= n_rd;
        r_wr         <= n_wr;
        r_mode       <= n_mode;
        r_drop       <= n_drop;
        r_ins_done   <= n_ins_done;
        r_value      <= n_value;
        r_pend_valid <= n_pend_valid;
        r_pend_value <= n_pend_value;
        r_o_value    <= n_o_value;
        r_o_empty    <= n_o_empty;
        r_o_last     <= n_o_last;
        r_o_drop     <= n_o_drop;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.item_value     = r_o_value;
    assign o_out.list_empty     = r_o_empty;
    assign o_out.last           = r_o_last;
    assign o_out.insert_dropped = r_o_drop;

endmodule : sorted_list_insert_delete_top

`default_nettype wire

/* design/sli_checker.sv */
// Port-level checks for the sorted list block, bound to its top level.
// Depends on sli_pkg and on the port names of sorted_list_insert_delete_top.
`default_nettype none

module sli_checker
    import sli_pkg::*;
(
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     i_in_ready,
    input wire                     i_out_valid,
    input wire                     i_out_ready,
    input wire signed [DATA_W-1:0] i_out_value,
    input wire                     i_out_empty,
    input wire                     i_out_last,
    input wire                     i_out_drop
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_last)))
        else $error("stalled result changed");

    // Once a request is taken, the block is not ready in the cycle after.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    // Only the final result of a request may wait while a new request is taken.
    a_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("ready while a list is still being sent");

    // An empty marker is alone, final, carries zero and never flags a dropped insert.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_empty) |->
            (i_out_last && (i_out_value == '0) && !i_out_drop))
        else $error("malformed empty result");

endmodule : sli_checker

bind sorted_list_insert_delete_top sli_checker u_sli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.item_value),
    .i_out_empty (o_out.list_empty),
    .i_out_last  (o_out.last),
    .i_out_drop  (o_out.insert_dropped)
);

`default_nettype wire
